/* rtl/vts_pkg.sv */
// Package for the voice table: sizes, codes and the types shared by
// the interfaces, the voice cells and the sequencer. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vts_pkg;

  localparam int unsigned TABLE_DEPTH = 32;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int unsigned ACTION_W  = 2;
  localparam int unsigned SOUND_W   = 8;
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned OCOUNT_W  = 6;
  localparam int unsigned MAXV_W    = 6;
  localparam logic [MAXV_W-1:0] MAXV_RESET = MAXV_W'(8);

  localparam int unsigned CMP_W = (CNT_W > MAXV_W) ? CNT_W : MAXV_W;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PLAY    = 2'd0,
    ACT_FINISH  = 2'd1,
    ACT_BUF_END = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPEND,
    ST_PASS,
    ST_DONE
  } seq_state_e;

  typedef enum logic [1:0] {
    OP_MARK_NP,
    OP_MARK_ANY,
    OP_FIND,
    OP_DROP
  } pass_op_e;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_APPEND,
    CMD_STEP
  } cell_cmd_e;

  typedef struct packed {
    logic [SOUND_W-1:0] sound;
    logic               prio;
    logic               dropped;
    logic [GAIN_W-1:0]  gain;
  } voice_t;

  typedef struct packed {
    cell_cmd_e          cmd;
    logic [CNT_W-1:0]   len;
    logic               keep;
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* rtl/vts_in_if.sv */
// Input channel of the voice table: valid/ready handshake and one event word.
// Depends on vts_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface vts_in_if;
  import vts_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [SOUND_W-1:0]  sound_id;
  logic                priority_req;
  logic [GAIN_W-1:0]   loudness;

  modport source (output valid, output action, output sound_id, output priority_req,
                  output loudness, input ready);
  modport sink   (input valid, input action, input sound_id, input priority_req,
                  input loudness, output ready);
endinterface

`default_nettype wire

/* rtl/vts_out_if.sv */
// Result channel of the voice table: valid/ready handshake and one result word.
// Depends on vts_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface vts_out_if;
  import vts_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                drop_marked;
  logic [SOUND_W-1:0]  dropped_sound_id;
  logic [OCOUNT_W-1:0] removed_count;
  logic [OCOUNT_W-1:0] active_count;

  modport source (output valid, output status, output drop_marked,
                  output dropped_sound_id, output removed_count,
                  output active_count, input ready);
  modport sink   (input valid, input status, input drop_marked,
                  input dropped_sound_id, input removed_count,
                  input active_count, output ready);
endinterface

`default_nettype wire

/* rtl/vts_cell.sv */
// One voice cell of the table chain: holds one voice and takes its
// neighbor's voice or the tail voice under the broadcast command. Uses vts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vts_cell (
  input  logic                      clk_i,
  input  logic [vts_pkg::IDX_W-1:0] idx_i,
  input  vts_pkg::cell_ctrl_t       ctrl_i,
  input  vts_pkg::voice_t           right_i,
  input  vts_pkg::voice_t           tail_i,
  output vts_pkg::voice_t           entry_o
);
  import vts_pkg::*;

  voice_t           entry_q;
  voice_t           entry_d;
  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] pos_next;

  assign pos      = CNT_W'(idx_i);
  assign pos_next = pos + CNT_W'(1);

  // During a step every cell below the live tail moves one place toward
  // the head; the last live cell takes the voice that comes back around, if it is kept.
  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.cmd)
      CMD_APPEND: begin
        if (pos == ctrl_i.len) begin
          entry_d = tail_i;
        end
      end
      CMD_STEP: begin
        if (pos_next < ctrl_i.len) begin
          entry_d = right_i;
        end else if (pos_next == ctrl_i.len && ctrl_i.keep) begin
          entry_d = tail_i;
        end
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

/* rtl/vts_seq.sv */
// Sequencer of the voice table: takes events, drives the cell chain through
// append and rotation passes, and holds the result word. Uses vts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vts_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         max_voices_we_i,
  input  logic [vts_pkg::MAXV_W-1:0]   max_voices_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [vts_pkg::ACTION_W-1:0] in_action_i,
  input  logic [vts_pkg::SOUND_W-1:0]  in_sound_id_i,
  input  logic                         in_priority_req_i,
  input  logic [vts_pkg::GAIN_W-1:0]   in_loudness_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [vts_pkg::STATUS_W-1:0] out_status_o,
  output logic                         out_drop_marked_o,
  output logic [vts_pkg::SOUND_W-1:0]  out_dropped_sound_id_o,
  output logic [vts_pkg::OCOUNT_W-1:0] out_removed_count_o,
  output logic [vts_pkg::OCOUNT_W-1:0] out_active_count_o,
  input  vts_pkg::voice_t              head_i,
  output vts_pkg::cell_ctrl_t          ctrl_o,
  output vts_pkg::voice_t              tail_o
);
  import vts_pkg::*;

  // Control state.
  seq_state_e          state_q, state_d;
  pass_op_e            op_q, op_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [MAXV_W-1:0]   max_q;
  logic                out_valid_q, out_valid_d;

  // Working registers of the current event.
  logic [SOUND_W-1:0]  sid_q, sid_d;
  logic                prio_q, prio_d;
  logic [GAIN_W-1:0]   gain_q, gain_d;
  logic [CNT_W-1:0]    len_q, len_d;
  logic [CNT_W-1:0]    step_q, step_d;
  logic                found_q, found_d;
  logic                any_q, any_d;
  status_e             status_q, status_d;
  logic                marked_q, marked_d;
  logic [SOUND_W-1:0]  marked_id_q, marked_id_d;
  logic [CNT_W-1:0]    removed_q, removed_d;

  // Result word.
  logic [STATUS_W-1:0] o_status_q, o_status_d;
  logic                o_marked_q, o_marked_d;
  logic [SOUND_W-1:0]  o_marked_id_q, o_marked_id_d;
  logic [OCOUNT_W-1:0] o_removed_q, o_removed_d;
  logic [OCOUNT_W-1:0] o_active_q, o_active_d;

  logic                hit;
  logic                keep;
  logic                mark_op;
  voice_t              head_out;
  voice_t              new_voice;
  logic                load_out;
  logic                accept;
  logic                full;
  logic                over_limit;

  assign new_voice = '{sound: sid_q, prio: prio_q, dropped: 1'b0, gain: gain_q};
  assign accept    = in_valid_i && in_ready_o;
  assign full      = (count_q == CNT_W'(TABLE_DEPTH));
  assign over_limit = CMP_W'(count_q + CNT_W'(1)) > CMP_W'(max_q);
  assign load_out  = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  assign mark_op   = (op_q == OP_MARK_NP) || (op_q == OP_MARK_ANY);

  // Decision on the voice leaving the head of the chain.
  always_comb begin
    hit      = 1'b0;
    keep     = 1'b1;
    head_out = head_i;
    case (op_q)
      OP_MARK_NP:  hit = !found_q && !head_i.dropped && !head_i.prio;
      OP_MARK_ANY: hit = !found_q && !head_i.dropped;
      OP_FIND: begin
        hit  = !found_q && (head_i.sound == sid_q);
        keep = !hit;
      end
      OP_DROP: begin
        hit  = head_i.dropped;
        keep = !hit;
      end
      default: hit = 1'b0;
    endcase
    if (mark_op && hit) begin
      head_out.dropped = 1'b1;
    end
  end

  // Next state and working registers.
  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    count_d       = count_q;
    sid_d         = sid_q;
    prio_d        = prio_q;
    gain_d        = gain_q;
    len_d         = len_q;
    step_d        = step_q;
    found_d       = found_q;
    any_d         = any_q;
    status_d      = status_q;
    marked_d      = marked_q;
    marked_id_d   = marked_id_q;
    removed_d     = removed_q;
    out_valid_d   = out_valid_q;
    o_status_d    = o_status_q;
    o_marked_d    = o_marked_q;
    o_marked_id_d = o_marked_id_q;
    o_removed_d   = o_removed_q;
    o_active_d    = o_active_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          sid_d       = in_sound_id_i;
          prio_d      = in_priority_req_i;
          gain_d      = in_loudness_i;
          status_d    = STAT_OK;
          marked_d    = 1'b0;
          marked_id_d = '0;
          removed_d   = '0;
          found_d     = 1'b0;
          any_d       = 1'b0;
          len_d       = count_q;
          step_d      = count_q;
          case (action_e'(in_action_i))
            ACT_PLAY: begin
              if (full) begin
                status_d = STAT_FULL;
                state_d  = ST_DONE;
              end else begin
                state_d = ST_APPEND;
              end
            end
            ACT_FINISH: begin
              op_d    = OP_FIND;
              state_d = ST_PASS;
            end
            ACT_BUF_END: begin
              op_d    = OP_DROP;
              state_d = ST_PASS;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_APPEND: begin
        count_d = count_q + CNT_W'(1);
        if (over_limit) begin
          op_d    = OP_MARK_NP;
          len_d   = count_q + CNT_W'(1);
          step_d  = count_q + CNT_W'(1);
          state_d = ST_PASS;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_PASS: begin
        if (step_q == '0) begin
          count_d = len_q;
          case (op_q)
            OP_MARK_NP: begin
              // Only priority voices are left undropped: second pass.
              if (!found_q && any_q) begin
                op_d   = OP_MARK_ANY;
                step_d = len_q;
              end else begin
                state_d = ST_DONE;
              end
            end
            OP_FIND: begin
              if (!found_q) begin
                status_d = STAT_NOT_FOUND;
              end
              state_d = ST_DONE;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end else begin
          step_d = step_q - CNT_W'(1);
          if (hit) begin
            found_d = 1'b1;
          end
          if (!keep) begin
            len_d     = len_q - CNT_W'(1);
            removed_d = removed_q + CNT_W'(1);
          end
          if (mark_op && hit) begin
            marked_d    = 1'b1;
            marked_id_d = head_i.sound;
          end
          if (op_q == OP_MARK_NP && !head_i.dropped) begin
            any_d = 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (load_out) begin
          out_valid_d   = 1'b1;
          o_status_d    = status_q;
          o_marked_d    = marked_q;
          o_marked_id_d = marked_id_q;
          o_removed_d   = OCOUNT_W'(removed_q);
          o_active_d    = OCOUNT_W'(count_q);
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Commands to the cell chain and the handshake.
  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    ctrl_o     = '{cmd: CMD_HOLD, len: len_q, keep: keep};
    tail_o     = head_out;
    case (state_q)
      ST_APPEND: begin
        ctrl_o = '{cmd: CMD_APPEND, len: count_q, keep: 1'b1};
        tail_o = new_voice;
      end
      ST_PASS: begin
        if (step_q != '0) begin
          ctrl_o = '{cmd: CMD_STEP, len: len_q, keep: keep};
        end
      end
      default: begin
        ctrl_o = '{cmd: CMD_HOLD, len: len_q, keep: keep};
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_MARK_NP;
      count_q     <= '0;
      max_q       <= MAXV_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (max_voices_we_i) begin
        max_q <= max_voices_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sid_q         <= sid_d;
    prio_q        <= prio_d;
    gain_q        <= gain_d;
    len_q         <= len_d;
    step_q        <= step_d;
    found_q       <= found_d;
    any_q         <= any_d;
    status_q      <= status_d;
    marked_q      <= marked_d;
    marked_id_q   <= marked_id_d;
    removed_q     <= removed_d;
    o_status_q    <= o_status_d;
    o_marked_q    <= o_marked_d;
    o_marked_id_q <= o_marked_id_d;
    o_removed_q   <= o_removed_d;
    o_active_q    <= o_active_d;
  end

  assign out_valid_o            = out_valid_q;
  assign out_status_o           = o_status_q;
  assign out_drop_marked_o      = o_marked_q;
  assign out_dropped_sound_id_o = o_marked_id_q;
  assign out_removed_count_o    = o_removed_q;
  assign out_active_count_o     = o_active_q;

endmodule

`default_nettype wire

/* rtl/voice_table_with_steal.sv */
// Voice table with oldest-voice stealing. A rejected play or the unused action goes
// straight to the result; a play appends the voice and, over max_voices, runs a marking
// pass, and a second one when only priority voices are left to mark; finish and buffer
// end run one pass. Each pass steps once through every live voice. A new event is taken
// only after the last one's result is loaded, which waits while a result is pending.
// Reset (rst_ni, asynchronous, low) empties the table and sets max_voices to 8.
`timescale 1ns / 1ps
`default_nettype none

module voice_table_with_steal (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       max_voices_we_i,
  input  logic [vts_pkg::MAXV_W-1:0] max_voices_i,
  vts_in_if.sink                     in_i,
  vts_out_if.source                  out_o
);
  import vts_pkg::*;

  // The table is a row of voice cells, oldest voice in cell 0. Every event
  // that has to look at the voices in age order runs a pass: for each live
  // voice the head cell's word goes to the sequencer, all live cells move one
  // place toward the head, and the sequencer hands the word back to the last
  // live cell, marked for dropping where needed, or lets it vanish when the
  // voice is removed. After a pass of N steps the survivors stand in their old
  // order, packed from cell 0, so removals compact the table for free.
  //
  // A play first writes the new voice into the cell just past the live ones.
  // If the count then exceeds max_voices a marking pass looks for the oldest
  // voice that is neither dropped nor priority; if there is none but some
  // undropped voice was seen, a second pass marks the oldest undropped voice.
  //
  // Cells beyond the live count hold stale words and are never looked at; the
  // cell storage has no reset.
  //
  // The result word sits in its own register, so the next event is taken while
  // an earlier result still waits on the output side.

  cell_ctrl_t cell_ctrl;
  voice_t     tail_voice;
  voice_t     cell_voice [TABLE_DEPTH];

  vts_seq u_seq (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .max_voices_we_i        (max_voices_we_i),
    .max_voices_i           (max_voices_i),
    .in_valid_i             (in_i.valid),
    .in_ready_o             (in_i.ready),
    .in_action_i            (in_i.action),
    .in_sound_id_i          (in_i.sound_id),
    .in_priority_req_i      (in_i.priority_req),
    .in_loudness_i          (in_i.loudness),
    .out_valid_o            (out_o.valid),
    .out_ready_i            (out_o.ready),
    .out_status_o           (out_o.status),
    .out_drop_marked_o      (out_o.drop_marked),
    .out_dropped_sound_id_o (out_o.dropped_sound_id),
    .out_removed_count_o    (out_o.removed_count),
    .out_active_count_o     (out_o.active_count),
    .head_i                 (cell_voice[0]),
    .ctrl_o                 (cell_ctrl),
    .tail_o                 (tail_voice)
  );

  // The last cell never shifts from a right neighbor, so it sees the tail word.
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    if (g == TABLE_DEPTH - 1) begin : g_last
      vts_cell u_cell (
        .clk_i   (clk_i),
        .idx_i   (IDX_W'(g)),
        .ctrl_i  (cell_ctrl),
        .right_i (tail_voice),
        .tail_i  (tail_voice),
        .entry_o (cell_voice[g])
      );
    end else begin : g_mid
      vts_cell u_cell (
        .clk_i   (clk_i),
        .idx_i   (IDX_W'(g)),
        .ctrl_i  (cell_ctrl),
        .right_i (cell_voice[g+1]),
        .tail_i  (tail_voice),
        .entry_o (cell_voice[g])
      );
    end
  end

endmodule

`default_nettype wire
